// ----- rtl/rbts_pkg.sv -----
// shared types, constants and helpers for the rank bucket task scheduler
package rbts_pkg;

  // fixed widths of the request and result fields
  localparam int NODE_PORT_W = 8;
  localparam int RANK_PORT_W = 6;
  localparam int NODE_SPACE  = 2 ** NODE_PORT_W;

  // rank search walks the non-empty mask in groups of this many ranks
  localparam int GRP_W    = 3;
  localparam int GRP_SIZE = 2 ** GRP_W;

  // request type codes
  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_ADVANCE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_ADV,
    ST_SCAN,
    ST_DETACH
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic sched;
    logic adv;
    logic scan;
    logic detach;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic has_next;
    logic scan_hit;
    logic scan_exhausted;
  } ctl_sts_t;

  // index of the lowest set bit of one group
  function automatic logic [GRP_W-1:0] first_set(input logic [GRP_SIZE-1:0] v);
    logic [GRP_W-1:0] idx;
    idx = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = GRP_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/rbts_ram.sv -----
// generic single write port ram with registered read
module rbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rbts_ctrl.sv -----
// request sequencer of the rank bucket task scheduler
module rbts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_req_type,
  input  rbts_pkg::ctl_sts_t sts,
  output logic              busy,
  output rbts_pkg::ctl_cmd_t cmd
);
  import rbts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_req_type == REQ_ADVANCE) ? ST_ADV : ST_SCHED;
        end
      end
      ST_SCHED: begin
        state_nxt = ST_IDLE;
      end
      ST_ADV: begin
        state_nxt = sts.has_next ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          state_nxt = ST_DETACH;
        end else if (sts.scan_exhausted) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DETACH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_SCHED:  cmd.sched  = 1'b1;
      ST_ADV:    cmd.adv    = 1'b1;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DETACH: cmd.detach = 1'b1;
      default:   busy       = 1'b1;
    endcase
  end

endmodule

// ----- rtl/rbts_dp.sv -----
// datapath: rank lists, node marks, rank search and result register
module rbts_dp #(
  parameter int MAX_RANKS = 64,
  parameter int MAX_NODES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rbts_pkg::ctl_cmd_t                 cmd,
  output rbts_pkg::ctl_sts_t                 sts,
  input  logic [rbts_pkg::NODE_PORT_W-1:0]   in_node_id,
  input  logic [rbts_pkg::RANK_PORT_W-1:0]   in_node_rank,
  output logic                               out_strobe,
  output logic                               out_accepted,
  output logic [rbts_pkg::NODE_PORT_W-1:0]   out_node,
  output logic                               out_valid,
  output logic                               out_cycle_done
);
  import rbts_pkg::*;

  // only ids that fit the node field can ever arrive
  localparam int NODE_CNT = (MAX_NODES < NODE_SPACE) ? MAX_NODES : NODE_SPACE;
  localparam int NW       = $clog2(NODE_CNT);
  localparam int RW       = $clog2(MAX_RANKS);
  localparam int NGRP_RAW = (MAX_RANKS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NGW      = (NGRP_RAW > 2) ? $clog2(NGRP_RAW) : 1;
  localparam int NGRP     = 2 ** NGW;
  localparam int PADW     = NGRP * GRP_SIZE;
  localparam int SPW      = NGW + GRP_W + 1;

  logic [NODE_PORT_W-1:0] req_node_r;
  logic [RANK_PORT_W-1:0] req_rank_r;
  logic [NODE_CNT-1:0]    marked_r, marked_nxt;
  logic [MAX_RANKS-1:0]   nonempty_r, nonempty_nxt;
  logic                   cycle_active_r, cycle_active_nxt;
  logic [RW-1:0]          cur_r, cur_nxt;
  logic [NW-1:0]          handed_r, handed_nxt;
  logic                   handed_valid_r, handed_valid_nxt;
  logic [NW-1:0]          det_tail_r, det_tail_nxt;
  logic [SPW-1:0]         scan_pos_r, scan_pos_nxt;

  logic                   out_strobe_r, out_strobe_nxt;
  logic                   out_accepted_r, out_accepted_nxt;
  logic [NODE_PORT_W-1:0] out_node_r, out_node_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_cycle_done_r, out_cycle_done_nxt;

  logic [NW-1:0]       req_n;
  logic [RW-1:0]       req_rk;
  logic                sched_ok;
  logic                rank_was_set;
  logic [PADW-1:0]     ne_pad;
  logic [NGW-1:0]      scan_grp;
  logic [GRP_W-1:0]    scan_off;
  logic                scan_past;
  logic [GRP_SIZE-1:0] window;
  logic                scan_hit;
  logic                scan_exhausted;
  logic [RW-1:0]       found_rank;
  logic                has_next;
  logic [SPW-1:0]      scan_start;

  logic [NW-1:0] link_rdata, head_rdata, tail_rdata;
  logic          link_we, head_we, tail_we;
  logic [RW-1:0] tail_raddr;

  // request decode
  assign req_n        = NW'(req_node_r);
  assign req_rk       = RW'(req_rank_r);
  assign sched_ok     = (int'(req_node_r) < MAX_NODES) && (int'(req_rank_r) < MAX_RANKS) &&
                        !marked_r[req_n];
  assign rank_was_set = nonempty_r[req_rk];

  // rank search: one group of ranks per cycle, lowest rank first
  assign ne_pad         = PADW'(nonempty_r);
  assign scan_grp       = scan_pos_r[GRP_W +: NGW];
  assign scan_off       = scan_pos_r[GRP_W-1:0];
  assign scan_past      = scan_pos_r[SPW-1];
  assign window         = ne_pad[scan_grp*GRP_SIZE +: GRP_SIZE] &
                          ({GRP_SIZE{1'b1}} << scan_off);
  assign scan_hit       = !scan_past && (|window);
  assign scan_exhausted = scan_past || (!scan_hit && (scan_grp == {NGW{1'b1}}));
  assign found_rank     = RW'({scan_grp, first_set(window)});
  assign scan_start     = cycle_active_r ? (SPW'(cur_r) + SPW'(1)) : '0;

  // the handed node has a successor unless it is the detached tail
  assign has_next = handed_valid_r && (handed_r != det_tail_r);

  assign sts.has_next       = has_next;
  assign sts.scan_hit       = scan_hit;
  assign sts.scan_exhausted = scan_exhausted;

  // list memories
  assign link_we    = cmd.sched && sched_ok && rank_was_set;
  assign head_we    = cmd.sched && sched_ok && !rank_was_set;
  assign tail_we    = cmd.sched && sched_ok;
  assign tail_raddr = cmd.scan ? found_rank : RW'(in_node_rank);

  rbts_ram #(.WIDTH(NW), .DEPTH(NODE_CNT)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (tail_rdata),
    .wdata (req_n),
    .raddr (handed_r),
    .rdata (link_rdata)
  );

  rbts_ram #(.WIDTH(NW), .DEPTH(MAX_RANKS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (req_rk),
    .wdata (req_n),
    .raddr (found_rank),
    .rdata (head_rdata)
  );

  rbts_ram #(.WIDTH(NW), .DEPTH(MAX_RANKS)) u_tail_ram (
    .clk   (clk),
    .we    (tail_we),
    .waddr (req_rk),
    .wdata (req_n),
    .raddr (tail_raddr),
    .rdata (tail_rdata)
  );

  // state updates and result
  always_comb begin
    marked_nxt         = marked_r;
    nonempty_nxt       = nonempty_r;
    cycle_active_nxt   = cycle_active_r;
    cur_nxt            = cur_r;
    handed_nxt         = handed_r;
    handed_valid_nxt   = handed_valid_r;
    det_tail_nxt       = det_tail_r;
    scan_pos_nxt       = scan_pos_r;
    out_strobe_nxt     = 1'b0;
    out_accepted_nxt   = 1'b0;
    out_node_nxt       = '0;
    out_valid_nxt      = 1'b0;
    out_cycle_done_nxt = 1'b0;

    // schedule: append to the rank list and mark
    if (cmd.sched) begin
      out_strobe_nxt   = 1'b1;
      out_accepted_nxt = sched_ok;
      if (sched_ok) begin
        marked_nxt[req_n]    = 1'b1;
        nonempty_nxt[req_rk] = 1'b1;
      end
    end

    // advance: release the handed node, follow its link if any
    if (cmd.adv) begin
      scan_pos_nxt = scan_start;
      if (handed_valid_r) begin
        marked_nxt[handed_r] = 1'b0;
        handed_valid_nxt     = 1'b0;
      end
      if (has_next) begin
        handed_nxt       = link_rdata;
        handed_valid_nxt = 1'b1;
        out_strobe_nxt   = 1'b1;
        out_node_nxt     = NODE_PORT_W'(link_rdata);
        out_valid_nxt    = 1'b1;
      end
    end

    // search for the next non-empty rank
    if (cmd.scan) begin
      scan_pos_nxt = {1'b0, scan_grp + NGW'(1), {GRP_W{1'b0}}};
      if (scan_grp == {NGW{1'b1}}) begin
        scan_pos_nxt = {1'b1, {(SPW-1){1'b0}}};
      end
      if (scan_hit) begin
        nonempty_nxt[found_rank] = 1'b0;
        cur_nxt                  = found_rank;
        cycle_active_nxt         = 1'b1;
      end else if (scan_exhausted) begin
        cycle_active_nxt   = 1'b0;
        cur_nxt            = '0;
        out_strobe_nxt     = 1'b1;
        out_cycle_done_nxt = 1'b1;
      end
    end

    // detach the found list and hand out its head
    if (cmd.detach) begin
      handed_nxt       = head_rdata;
      handed_valid_nxt = 1'b1;
      det_tail_nxt     = tail_rdata;
      out_strobe_nxt   = 1'b1;
      out_node_nxt     = NODE_PORT_W'(head_rdata);
      out_valid_nxt    = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marked_r       <= '0;
      nonempty_r     <= '0;
      cycle_active_r <= 1'b0;
      cur_r          <= '0;
      handed_r       <= '0;
      handed_valid_r <= 1'b0;
      out_strobe_r   <= 1'b0;
    end else begin
      marked_r       <= marked_nxt;
      nonempty_r     <= nonempty_nxt;
      cycle_active_r <= cycle_active_nxt;
      cur_r          <= cur_nxt;
      handed_r       <= handed_nxt;
      handed_valid_r <= handed_valid_nxt;
      out_strobe_r   <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_node_r <= in_node_id;
      req_rank_r <= in_node_rank;
    end
    det_tail_r       <= det_tail_nxt;
    scan_pos_r       <= scan_pos_nxt;
    out_accepted_r   <= out_accepted_nxt;
    out_node_r       <= out_node_nxt;
    out_valid_r      <= out_valid_nxt;
    out_cycle_done_r <= out_cycle_done_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_accepted   = out_accepted_r;
  assign out_node       = out_node_r;
  assign out_valid      = out_valid_r;
  assign out_cycle_done = out_cycle_done_r;

endmodule

// ----- rtl/rank_bucket_task_scheduler.sv -----
// top level of the rank bucket task scheduler
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with out_strobe, in the cycle after the request's
// last internal step, and cannot be held off. A schedule request reads the
// tail of the rank list, then does the link, head and tail writes. An
// advance that continues the current list reads the link of the node
// handed out before. Otherwise the next non-empty rank is searched 8 ranks
// per cycle upward from the rank after the current one, or from rank 0
// when no cycle is active: an advance that finds one then detaches that
// rank's list and hands out its head, and one that finds none ends the
// cycle. No clearing pass is needed after reset.
module rank_bucket_task_scheduler #(
  parameter int MAX_RANKS = 64,
  parameter int MAX_NODES = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [rbts_pkg::NODE_PORT_W-1:0] in_node_id,
  input  logic [rbts_pkg::RANK_PORT_W-1:0] in_node_rank,
  output logic                             out_strobe,
  output logic                             out_accepted,
  output logic [rbts_pkg::NODE_PORT_W-1:0] out_node,
  output logic                             out_valid,
  output logic                             out_cycle_done
);
  import rbts_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  rbts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .busy        (busy),
    .cmd         (cmd)
  );

  // lists, marks and rank search
  rbts_dp #(
    .MAX_RANKS (MAX_RANKS),
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_node_id     (in_node_id),
    .in_node_rank   (in_node_rank),
    .out_strobe     (out_strobe),
    .out_accepted   (out_accepted),
    .out_node       (out_node),
    .out_valid      (out_valid),
    .out_cycle_done (out_cycle_done)
  );

`ifndef SYNTHESIS
  // an accepted request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // a result only follows internal work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a request in progress");

  // a result is a schedule answer, a node, or the end of a cycle, never two
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_valid && out_cycle_done) && !(out_accepted && out_valid) &&
                   !(out_accepted && out_cycle_done))
    else $error("result mixes request kinds");

  // a rank search step never both hits and runs out
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !(sts.scan_hit && sts.scan_exhausted))
    else $error("rank search both hit and exhausted");
`endif

endmodule
